@@ src/tss_pkg.sv @@
package tss_pkg;

  localparam int NUM_SERVOS  = 16;
  localparam int CH_W        = $clog2(NUM_SERVOS);
  localparam int GROUP_W     = 8;
  localparam int TICK_W      = 12;
  localparam int ANGLE_W     = 8;
  localparam int PROD_W      = ANGLE_W + TICK_W;
  localparam int MUL_W       = 21;
  localparam int RECIP_SHIFT = 28;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_BUS  = 2'd1;
  localparam logic [1:0] FUNC_CAL  = 2'd2;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_MIN_TICK = 2'd1;
  localparam logic [1:0] REG_MAX_TICK = 2'd2;

  localparam logic signed [7:0] REL_LOW   = -8'sd90;
  localparam logic signed [7:0] REL_HIGH  = 8'sd90;
  localparam logic [7:0]        PHYS_MAX  = 8'd180;
  localparam logic [8:0]        DIVISOR   = 9'd180;
  // ceil(2^28 / 180), exact for every product of angle and span
  localparam logic [MUL_W-1:0]  RECIP_180 = 21'd1491309;

  typedef struct packed {
    logic [7:0]        zero;
    logic signed [7:0] left;
    logic signed [7:0] right;
    logic              div_left;
  } cal_entry_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] idx;
    cal_entry_t      entry;
  } cal_wr_t;

  localparam cal_entry_t CAL_RESET = '{
    zero:     8'd90,
    left:     -8'sd40,
    right:    8'sd40,
    div_left: 1'b1
  };

endpackage

@@ src/tss_angle.sv @@
module tss_angle
  import tss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cal_wr_t                cal_wr,
  input  logic [CH_W-1:0]        sel_ch,
  input  logic                   sel_div,
  output logic [ANGLE_W-1:0]     phys
);

  cal_entry_t        table_q [NUM_SERVOS];
  cal_entry_t        ent;
  logic signed [7:0] sel;
  logic signed [7:0] r1;
  logic signed [7:0] r2;
  logic signed [7:0] r3;
  logic signed [7:0] r4;
  logic signed [7:0] rel;
  logic signed [9:0] sum;
  logic [7:0]        ent_zero;

  assign ent = table_q[sel_ch];

  always_comb begin
    if (sel_div) begin
      sel = ent.div_left ? ent.left : ent.right;
    end else begin
      sel = ent.div_left ? ent.right : ent.left;
    end
    r1 = (sel < REL_LOW) ? REL_LOW : sel;
    r2 = (r1 > REL_HIGH) ? REL_HIGH : r1;
    r3 = (r2 < ent.left) ? ent.left : r2;
    r4 = (r3 > ent.right) ? ent.right : r3;
  end

  // second stage uses the registered relative angle
  assign sum = $signed({2'b00, ent_zero}) + {{2{rel[7]}}, rel};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        table_q[i] <= CAL_RESET;
      end
    end else if (cal_wr.en) begin
      table_q[cal_wr.idx] <= cal_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    rel      <= r4;
    ent_zero <= ent.zero;
    if (sum < 10'sd0) begin
      phys <= '0;
    end else if (sum > $signed({2'b00, PHYS_MAX})) begin
      phys <= PHYS_MAX;
    end else begin
      phys <= sum[7:0];
    end
  end

endmodule

@@ src/tss_scale.sv @@
module tss_scale
  import tss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ANGLE_W-1:0] phys,
  input  logic [TICK_W-1:0]  min_tick,
  input  logic [TICK_W-1:0]  max_tick,
  output logic               done,
  output logic [TICK_W-1:0]  tick
);

  typedef enum logic {S_IDLE, S_DIV} sstate_t;

  sstate_t                  state;
  logic signed [TICK_W:0]   span;
  logic [TICK_W:0]          span_mag;
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [2*MUL_W-1:0]       prod;
  logic [PROD_W-1:0]        dvd;
  logic [TICK_W-1:0]        quo;
  logic                     neg;

  assign span     = $signed({1'b0, max_tick}) - $signed({1'b0, min_tick});
  assign span_mag = span[TICK_W] ? (~span + 1'b1) : span;
  // one multiplier: angle times span, then times the reciprocal of 180
  assign mul_a    = (state == S_IDLE) ? MUL_W'(phys) : MUL_W'(dvd);
  assign mul_b    = (state == S_IDLE) ? MUL_W'(span_mag[TICK_W-1:0]) : RECIP_180;
  assign prod     = mul_a * mul_b;
  assign tick     = neg ? (min_tick - quo) : (min_tick + quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DIV);
      case (state)
        S_IDLE: begin
          if (start) begin
            dvd   <= prod[PROD_W-1:0];
            neg   <= span[TICK_W];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quo   <= prod[RECIP_SHIFT+TICK_W-1:RECIP_SHIFT];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/turnout_servo_sequencer_core.sv @@
// Turnout servo sequencer: one request at a time. A tick, calibration write or bus
// update that moves no servo holds the block through a check state, and also through
// the round-robin scan when that walks all sixteen servos one per cycle and finds
// nothing. A request that switches a servo takes the scan, two angle stages and two
// passes through the shared multiplier (angle times tick span, then times
// a reciprocal for the divide by 180). Results sit in an output register, so the
// next request is taken while one waits; a further switch holds in its write state
// until that register is free.
module turnout_servo_sequencer_core
  import tss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              func,
  input  logic [7:0]              data_a,
  input  logic [7:0]              data_b,
  input  logic                    use_a,
  input  logic                    use_b,
  input  logic [3:0]              servo_index,
  input  logic [7:0]              zero_angle,
  input  logic signed [7:0]       left_limit,
  input  logic signed [7:0]       right_limit,
  input  logic                    diverging_left,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              servo_channel,
  output logic [11:0]             pwm_tick,
  output logic                    to_diverging
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SCAN, ST_SEL, ST_PHYS, ST_MUL, ST_DIV, ST_WRITE
  } state_t;

  state_t               state;
  logic [9:0]           switch_interval;
  logic [TICK_W-1:0]    min_tick;
  logic [TICK_W-1:0]    max_tick;
  logic [GROUP_W-1:0]   applied_a;
  logic [GROUP_W-1:0]   applied_b;
  logic [GROUP_W-1:0]   pend_data_a;
  logic [GROUP_W-1:0]   pend_data_b;
  logic [GROUP_W-1:0]   mask_a;
  logic [GROUP_W-1:0]   mask_b;
  logic [1:0]           group_flags;
  logic                 work_pending;
  logic [CH_W-1:0]      next_servo;
  logic [15:0]          elapsed_ms;
  logic [CH_W-1:0]      scan_n;
  logic [CH_W-1:0]      found_ch;
  logic                 found_val;

  logic                 in_accept;
  logic                 cfg_write;
  logic                 out_free;
  logic                 bus_hit;
  logic [GROUP_W-1:0]   new_mask_a;
  logic [GROUP_W-1:0]   new_mask_b;
  logic [CH_W-1:0]      scan_ch;
  logic [2:0]           scan_bit;
  logic                 scan_hit;
  logic                 scan_data;
  cal_wr_t              cal_wr;
  logic [ANGLE_W-1:0]   phys;
  logic                 scale_start;
  logic                 scale_done;
  logic [TICK_W-1:0]    scale_tick;

  assign pready    = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (paddr[3:2])
      REG_INTERVAL: prdata = {22'd0, switch_interval};
      REG_MIN_TICK: prdata = {20'd0, min_tick};
      REG_MAX_TICK: prdata = {20'd0, max_tick};
      default:      prdata = '0;
    endcase
  end

  assign bus_hit    = (use_a && (data_a != applied_a)) || (use_b && (data_b != applied_b));
  assign new_mask_a = use_a ? (data_a ^ applied_a) : '0;
  assign new_mask_b = use_b ? (data_b ^ applied_b) : '0;

  assign scan_ch   = next_servo + scan_n;
  assign scan_bit  = scan_ch[2:0];
  assign scan_hit  = scan_ch[3] ? (group_flags[1] && mask_b[scan_bit])
                                : (group_flags[0] && mask_a[scan_bit]);
  assign scan_data = scan_ch[3] ? pend_data_b[scan_bit] : pend_data_a[scan_bit];

  assign cal_wr.en             = in_accept && (func == FUNC_CAL);
  assign cal_wr.idx            = servo_index;
  assign cal_wr.entry.zero     = zero_angle;
  assign cal_wr.entry.left     = left_limit;
  assign cal_wr.entry.right    = right_limit;
  assign cal_wr.entry.div_left = diverging_left;

  assign scale_start = (state == ST_MUL);

  tss_angle u_angle (
    .clk     (clk),
    .rst     (rst),
    .cal_wr  (cal_wr),
    .sel_ch  (found_ch),
    .sel_div (found_val),
    .phys    (phys)
  );

  tss_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .start    (scale_start),
    .phys     (phys),
    .min_tick (min_tick),
    .max_tick (max_tick),
    .done     (scale_done),
    .tick     (scale_tick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      switch_interval <= 10'd35;
      min_tick        <= 12'd110;
      max_tick        <= 12'd500;
      applied_a       <= '1;
      applied_b       <= '1;
      pend_data_a     <= '0;
      pend_data_b     <= '0;
      mask_a          <= '0;
      mask_b          <= '0;
      group_flags     <= '0;
      work_pending    <= 1'b0;
      next_servo      <= '0;
      elapsed_ms      <= '0;
      scan_n          <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          REG_INTERVAL: switch_interval <= pwdata[9:0];
          REG_MIN_TICK: min_tick        <= pwdata[TICK_W-1:0];
          REG_MAX_TICK: max_tick        <= pwdata[TICK_W-1:0];
          default: ;
        endcase
      end
      out_valid <= (out_valid && out_stall) || ((state == ST_WRITE) && out_free);
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (func == FUNC_TICK) begin
              if (elapsed_ms != 16'hFFFF) begin
                elapsed_ms <= elapsed_ms + 16'd1;
              end
            end else if (func == FUNC_BUS && bus_hit) begin
              pend_data_a  <= data_a;
              pend_data_b  <= data_b;
              group_flags  <= {use_b, use_a};
              mask_a       <= new_mask_a;
              mask_b       <= new_mask_b;
              work_pending <= (new_mask_a != '0) || (new_mask_b != '0);
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          scan_n <= '0;
          if (work_pending && (elapsed_ms >= {6'd0, switch_interval})) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            found_ch  <= scan_ch;
            found_val <= scan_data;
            state     <= ST_SEL;
          end else if (scan_n == CH_W'(NUM_SERVOS - 1)) begin
            work_pending <= 1'b0;
            mask_a       <= '0;
            mask_b       <= '0;
            state        <= ST_IDLE;
          end else begin
            scan_n <= scan_n + 1'b1;
          end
        end
        ST_SEL:  state <= ST_PHYS;
        ST_PHYS: state <= ST_MUL;
        ST_MUL:  state <= ST_DIV;
        ST_DIV: begin
          if (scale_done) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            servo_channel <= found_ch;
            pwm_tick      <= scale_tick;
            to_diverging  <= found_val;
            if (found_ch[3]) begin
              applied_b[found_ch[2:0]] <= found_val;
              mask_b[found_ch[2:0]]    <= 1'b0;
            end else begin
              applied_a[found_ch[2:0]] <= found_val;
              mask_a[found_ch[2:0]]    <= 1'b0;
            end
            next_servo <= found_ch + 1'b1;
            elapsed_ms <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("block took a request without going busy");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (rst)
    scale_done |-> (state == ST_DIV))
    else $error("scale unit finished outside the divide wait");

  a_switch_restarts_gap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && out_free) |=> (out_valid && elapsed_ms == 16'd0))
    else $error("switch issued without result or gap timer restart");
`endif

endmodule
